// File: rtl/mwh_pkg.sv
// ----------------------------------------------------------------------------
// mwh_pkg: shared types and constants of the wide MurmurHash2 block
// Holds the mix constant, the control word layout and the microcode table
// that the sequencer steps through.
// ----------------------------------------------------------------------------
package mwh_pkg;

	// Mix multiplier and shift amounts
	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int          WORD_SHIFT  = 24;
	localparam int          FIN_SHIFT_A = 13;
	localparam int          FIN_SHIFT_B = 15;
	localparam int          WORD_BYTES  = 8;

	// Microcode address
	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] upc_t;

	// Register select for multiplier source and ALU destination
	typedef logic reg_sel_t;
	localparam reg_sel_t SEL_K = 1'b0;
	localparam reg_sel_t SEL_H = 1'b1;

	// ALU base operation
	typedef logic [1:0] alu_t;
	localparam alu_t ALU_NONE  = 2'd0; // no register write
	localparam alu_t ALU_MULHI = 2'd1; // low partial product plus high partial product
	localparam alu_t ALU_PASS  = 2'd2; // hash register as is
	localparam alu_t ALU_TAIL  = 2'd3; // hash register xor masked tail bytes

	// Xor-shift applied to the ALU result
	typedef logic [1:0] shf_t;
	localparam shf_t SHF_NONE = 2'd0;
	localparam shf_t SHF_24   = 2'd1;
	localparam shf_t SHF_13   = 2'd2;
	localparam shf_t SHF_15   = 2'd3;

	// Sequencing action
	typedef logic [1:0] seq_t;
	localparam seq_t SEQ_NEXT = 2'd0; // fall through
	localparam seq_t SEQ_GOTO = 2'd1; // jump to target when condition holds
	localparam seq_t SEQ_STOP = 2'd2; // end program when condition holds
	localparam seq_t SEQ_EMIT = 2'd3; // end program and deliver the hash

	// Branch conditions
	typedef logic [1:0] cond_t;
	localparam cond_t COND_ALWAYS   = 2'd0;
	localparam cond_t COND_NOT_FULL = 2'd1; // final beat with fewer than eight bytes
	localparam cond_t COND_EMPTY    = 2'd2; // beat with no bytes
	localparam cond_t COND_NOT_LAST = 2'd3;

	typedef struct packed {
		logic     mul_lo;
		reg_sel_t src;
		alu_t     alu;
		reg_sel_t dst;
		logic     xork;
		shf_t     shf;
		seq_t     seq;
		cond_t    cond;
		upc_t     target;
	} uword_t;

	typedef struct packed {
		logic last;
		logic full;
		logic empty;
	} dp_status_t;

	// Program entry points
	localparam upc_t UA_MIX  = 4'd0;
	localparam upc_t UA_FIN  = 4'd6;
	localparam upc_t UA_TAIL = 4'd9;

	localparam uword_t UW_NOP = '{mul_lo: 1'b0, src: SEL_K, alu: ALU_NONE, dst: SEL_K,
		xork: 1'b0, shf: SHF_NONE, seq: SEQ_NEXT, cond: COND_ALWAYS, target: UA_MIX};

	// Microcode program
	function automatic uword_t ucode_rom(upc_t addr);
		uword_t w;
		w = UW_NOP;
		unique case (addr)
			// word mix: k *= M (low half), branch off for a short final word
			4'd0: begin
				w.mul_lo = 1'b1;
				w.src    = SEL_K;
				w.seq    = SEQ_GOTO;
				w.cond   = COND_NOT_FULL;
				w.target = UA_TAIL;
			end
			// k *= M (high half), k ^= k >> 24
			4'd1: begin
				w.src = SEL_K;
				w.alu = ALU_MULHI;
				w.dst = SEL_K;
				w.shf = SHF_24;
			end
			4'd2: begin
				w.mul_lo = 1'b1;
				w.src    = SEL_K;
			end
			4'd3: begin
				w.src = SEL_K;
				w.alu = ALU_MULHI;
				w.dst = SEL_K;
			end
			4'd4: begin
				w.mul_lo = 1'b1;
				w.src    = SEL_H;
			end
			// h = h*M ^ k, stop here unless this is the final beat
			4'd5: begin
				w.src  = SEL_H;
				w.alu  = ALU_MULHI;
				w.dst  = SEL_H;
				w.xork = 1'b1;
				w.seq  = SEQ_STOP;
				w.cond = COND_NOT_LAST;
			end
			// finish: h ^= h >> 13
			4'd6: begin
				w.alu = ALU_PASS;
				w.dst = SEL_H;
				w.shf = SHF_13;
			end
			4'd7: begin
				w.mul_lo = 1'b1;
				w.src    = SEL_H;
			end
			// h *= M, h ^= h >> 15, deliver
			4'd8: begin
				w.src = SEL_H;
				w.alu = ALU_MULHI;
				w.dst = SEL_H;
				w.shf = SHF_15;
				w.seq = SEQ_EMIT;
			end
			// tail: xor in the valid bytes, skip the multiply when there are none
			4'd9: begin
				w.alu    = ALU_TAIL;
				w.dst    = SEL_H;
				w.seq    = SEQ_GOTO;
				w.cond   = COND_EMPTY;
				w.target = UA_FIN;
			end
			4'd10: begin
				w.mul_lo = 1'b1;
				w.src    = SEL_H;
			end
			4'd11: begin
				w.src    = SEL_H;
				w.alu    = ALU_MULHI;
				w.dst    = SEL_H;
				w.seq    = SEQ_GOTO;
				w.target = UA_FIN;
			end
			default: begin
				w.seq = SEQ_STOP;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/murmur2_wide_hash.sv
// ----------------------------------------------------------------------------
// murmur2_wide_hash: MurmurHash2-style hash over 64-bit message words
// Microcoded: a sequencer walks a control table that drives a datapath
// built around one shared 32x32 multiplier.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in      | sink      | in_valid/in_stall  | first_word, last_word, data_word,
//           |           |                    | byte_count, msg_length, seed_value
//   out     | source    | out_valid/out_stall| hash_value
//
// A non-final word runs the mix; a full final word runs the mix and the finish;
// a shorter final word gets the tail xor, a multiply if not empty, the finish;
// a beat outside a message is dropped. Each 64x32 multiply takes two passes
// through the 32x32 unit. The next beat is taken in the cycle the program
// finishes. Reset clears the hash to zero and closes any open message.
// A stalled result holds the delivery step; no new beat is taken meanwhile.
// ----------------------------------------------------------------------------
module murmur2_wide_hash import mwh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        first_word,
	input  logic        last_word,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic [31:0] msg_length,
	input  logic [63:0] seed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	logic        in_msg_q;
	logic        out_valid_q;
	logic [63:0] hash_q;

	logic        accept;
	logic        start;
	logic        out_free;
	uword_t      ctrl;
	dp_status_t  status;
	logic        step_en;
	logic        emit;
	logic        busy;
	logic [63:0] result;

	// Take a beat whenever the sequencer is free
	assign in_stall = busy;
	assign accept   = in_valid & ~in_stall;
	assign start    = accept & (first_word | in_msg_q);
	assign out_free = ~out_valid_q | ~out_stall;

	// Track the open message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
		end else if (start) begin
			in_msg_q <= ~last_word;
		end
	end

	mwh_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.status   (status),
		.out_free (out_free),
		.ctrl     (ctrl),
		.step_en  (step_en),
		.emit     (emit),
		.busy     (busy)
	);

	mwh_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (start),
		.first_word (first_word),
		.last_word  (last_word),
		.data_word  (data_word),
		.byte_count (byte_count),
		.msg_length (msg_length),
		.seed_value (seed_value),
		.ctrl       (ctrl),
		.step_en    (step_en),
		.status     (status),
		.result     (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hash_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

// File: rtl/mwh_useq.sv
// ----------------------------------------------------------------------------
// mwh_useq: microcode sequencer
// Steps a program counter through the control table, evaluates branch
// conditions from the datapath and reports when a program finishes.
// ----------------------------------------------------------------------------
module mwh_useq import mwh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	input  logic       out_free,
	output uword_t     ctrl,
	output logic       step_en,
	output logic       emit,
	output logic       busy
);

	upc_t pc_q;
	logic busy_q;
	logic cond_ok;
	logic hold;
	logic done;

	// Fetch the control word
	assign ctrl = ucode_rom(pc_q);

	// Evaluate the branch condition
	always_comb begin
		unique case (ctrl.cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_NOT_FULL: cond_ok = ~status.full;
			COND_EMPTY:    cond_ok = status.empty;
			COND_NOT_LAST: cond_ok = ~status.last;
			default:       cond_ok = 1'b0;
		endcase
	end

	// Hold the delivery step while the result slot is taken
	assign hold    = (ctrl.seq == SEQ_EMIT) & ~out_free;
	assign step_en = busy_q & ~hold;
	assign emit    = step_en & (ctrl.seq == SEQ_EMIT);
	assign done    = emit | (step_en & (ctrl.seq == SEQ_STOP) & cond_ok);
	assign busy    = busy_q & ~done;

	// Advance the program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= UA_MIX;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= UA_MIX;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (step_en) begin
			if ((ctrl.seq == SEQ_GOTO) && cond_ok) begin
				pc_q <= ctrl.target;
			end else begin
				pc_q <= upc_t'(pc_q + 1'b1);
			end
		end
	end

endmodule

// File: rtl/mwh_dpath.sv
// ----------------------------------------------------------------------------
// mwh_dpath: hash datapath
// Hash and key registers, one shared 32x32 multiplier with a partial
// product register, and an xor/shift ALU driven by the control word.
// ----------------------------------------------------------------------------
module mwh_dpath import mwh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic        first_word,
	input  logic        last_word,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic [31:0] msg_length,
	input  logic [63:0] seed_value,
	input  uword_t      ctrl,
	input  logic        step_en,
	output dp_status_t  status,
	output logic [63:0] result
);

	logic [63:0] h_q;
	logic [63:0] k_q;
	logic [63:0] p_q;
	logic        last_q;
	logic [3:0]  cnt_q;

	logic [63:0] opnd;
	logic [31:0] mul_a;
	logic [63:0] prod;
	logic [63:0] mask;
	logic [63:0] base;
	logic [63:0] x1;
	logic [63:0] sh;
	logic [3:0]  cnt_clamp;

	// Clamp oversized byte counts to a full word
	assign cnt_clamp = (byte_count > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : byte_count;

	assign status.last  = last_q;
	assign status.full  = ~last_q | (cnt_q == 4'(WORD_BYTES));
	assign status.empty = (cnt_q == 4'd0);

	// Pick multiplier half
	assign opnd  = (ctrl.src == SEL_K) ? k_q : h_q;
	assign mul_a = ctrl.mul_lo ? opnd[31:0] : opnd[63:32];
	assign prod  = 64'(mul_a) * 64'(MIX_MUL);

	// Build the tail byte mask
	always_comb begin
		for (int i = 0; i < WORD_BYTES; i++) begin
			mask[8*i +: 8] = {8{4'(i) < cnt_q}};
		end
	end

	// Select the ALU base value
	always_comb begin
		case (ctrl.alu)
			ALU_MULHI: base = p_q + {prod[31:0], 32'h0};
			ALU_TAIL:  base = h_q ^ (k_q & mask);
			default:   base = h_q;
		endcase
	end

	// Xor in the key and apply the xor-shift
	assign x1 = base ^ (ctrl.xork ? k_q : 64'h0);

	always_comb begin
		unique case (ctrl.shf)
			SHF_24:  sh = x1 >> WORD_SHIFT;
			SHF_13:  sh = x1 >> FIN_SHIFT_A;
			SHF_15:  sh = x1 >> FIN_SHIFT_B;
			default: sh = 64'h0;
		endcase
	end

	assign result = x1 ^ sh;

	// Hash register: a new message reloads it, otherwise the ALU writes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= 64'h0;
		end else if (load && first_word) begin
			h_q <= seed_value ^ {32'h0, msg_length};
		end else if (step_en && (ctrl.alu != ALU_NONE) && (ctrl.dst == SEL_H)) begin
			h_q <= result;
		end
	end

	// Key, partial product and beat attributes
	always_ff @(posedge clk) begin
		if (load) begin
			k_q    <= data_word;
			last_q <= last_word;
			cnt_q  <= cnt_clamp;
		end else if (step_en && (ctrl.alu != ALU_NONE) && (ctrl.dst == SEL_K)) begin
			k_q <= result;
		end
		if (step_en && ctrl.mul_lo) begin
			p_q <= prod;
		end
	end

endmodule

// File: rtl/mwh_checker.sv
// ----------------------------------------------------------------------------
// mwh_checker: port-level checks for the wide hash block
// Watches the handshakes on the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module mwh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        first_word,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] hash_value
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_value))
		else $error("stalled result beat changed");

	// A message start keeps the block busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && first_word |=> in_stall)
		else $error("block free right after a message start");

	// A new result only follows a running program
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall, 2))
		else $error("result appeared without a running program");

endmodule

bind murmur2_wide_hash mwh_checker u_mwh_checker (.*);

// File: bench/tb_murmur2_wide_hash.sv
// ----------------------------------------------------------------------------
// tb_murmur2_wide_hash: self-checking bench for the wide MurmurHash2 block
// Sends messages as 64-bit word beats under random idling on both sides.
// Each accepted beat goes through a local hash predictor, and every
// delivered hash is compared with the oldest hash still owed. Covers ignored
// stray beats, restarts, empty, short, full and oversized tails, and long
// output back-pressure.
// ----------------------------------------------------------------------------
module tb_murmur2_wide_hash;
	import mwh_pkg::*;

	localparam logic [63:0] MUL64      = {32'd0, MIX_MUL};
	localparam int          CLK_PERIOD = 12;
	localparam int          DRAIN_WAIT = 40;
	localparam int          RUN_LIMIT  = 600000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        first_word = 1'b0;
	logic        last_word = 1'b0;
	logic [63:0] data_word = '0;
	logic [3:0]  byte_count = '0;
	logic [31:0] msg_length = '0;
	logic [63:0] seed_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] hash_value;

	// Predictor state
	logic [63:0] running_hash = '0;
	logic        msg_open = 1'b0;
	logic [63:0] owed_hashes[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int beats_hashed = 0;
	int mismatch_count = 0;

	murmur2_wide_hash dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_word (first_word),
		.last_word  (last_word),
		.data_word  (data_word),
		.byte_count (byte_count),
		.msg_length (msg_length),
		.seed_value (seed_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Hash predictor
	// ------------------------------------------------------------------------
	function automatic logic [63:0] fold_word(logic [63:0] h, logic [63:0] k);
		k = k * MUL64;
		k = k ^ (k >> WORD_SHIFT);
		k = k * MUL64;
		h = h * MUL64;
		return h ^ k;
	endfunction

	function automatic logic [63:0] finish_mix(logic [63:0] h);
		h = h ^ (h >> FIN_SHIFT_A);
		h = h * MUL64;
		return h ^ (h >> FIN_SHIFT_B);
	endfunction

	// Update the running hash for one accepted beat; queue the hash it owes
	task automatic advance_hash(logic first, logic last, logic [63:0] data,
		logic [3:0] count, logic [31:0] len, logic [63:0] seed);
		logic [63:0] h;
		logic [63:0] keep;
		int          nbytes;
		// drop beats that arrive outside a message
		if (!first && !msg_open)
			return;
		beats_hashed++;
		h = first ? (seed ^ {32'd0, len}) : running_hash;
		nbytes = (count > WORD_BYTES) ? WORD_BYTES : int'(count);
		if (!last || nbytes == WORD_BYTES) begin
			h = fold_word(h, data);
		end else if (nbytes != 0) begin
			keep = (64'd1 << (nbytes * 8)) - 64'd1;
			h = (h ^ (data & keep)) * MUL64;
		end
		if (last) begin
			h = finish_mix(h);
			owed_hashes.push_back(h);
		end
		running_hash = h;
		msg_open = !last;
	endtask

	// ------------------------------------------------------------------------
	// Input side: call right after a rising edge with nothing driven yet
	// ------------------------------------------------------------------------
	task automatic send_beat(logic first, logic last, logic [63:0] data,
		logic [3:0] count, logic [31:0] len, logic [63:0] seed);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		first_word <= first;
		last_word  <= last;
		data_word  <= data;
		byte_count <= count;
		msg_length <= len;
		seed_value <= seed;
		// stall is settled mid-cycle; the next edge takes the beat when it is low
		do
			@(negedge clk);
		while (in_stall);
		@(posedge clk);
		advance_hash(first, last, data, count, len, seed);
	endtask

	// Lower valid and wait until every owed hash has been delivered
	task automatic wait_for_hashes();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (owed_hashes.size() != 0);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly eight bytes; sometimes any count from 0 to 15, which must be ignored
	function automatic logic [3:0] body_count();
		return ($urandom_range(99) < 90) ? 4'd8 : 4'($urandom_range(15));
	endfunction

	// ------------------------------------------------------------------------
	// Output side: stall pattern and result check
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH %s: expected %h got %h", what, want, got);
	endtask

	// Outputs are stable mid-cycle; a beat seen here is taken at the next edge
	always @(negedge clk) begin
		logic [63:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_hashes.size() == 0) begin
				note_mismatch("unexpected hash", 64'd0, hash_value);
			end else begin
				want = owed_hashes.pop_front();
				if (hash_value !== want)
					note_mismatch("hash_value", want, hash_value);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		int n;
		// stray beats with no open message
		send_beat(1'b0, 1'b1, '1, 4'd8, '1, '1);
		send_beat(1'b0, 1'b0, '1, 4'd15, '1, '1);
		// single-beat messages: empty tail, full tail, all zero
		send_beat(1'b1, 1'b1, '1, 4'd0, 32'd0, 64'd0);
		send_beat(1'b1, 1'b1, '1, 4'd8, '1, '1);
		send_beat(1'b1, 1'b1, 64'd0, 4'd8, 32'd0, 64'd0);
		// every short tail length
		for (n = 1; n < WORD_BYTES; n++)
			send_beat(1'b1, 1'b1, (n % 2) ? '1 : 64'hA5A5_5A5A_0F0F_F0F0, 4'(n),
				32'hFFFF_FFFF, 64'h5555_5555_AAAA_AAAA);
		// oversized counts behave as eight
		send_beat(1'b1, 1'b1, 64'h0123_4567_89AB_CDEF, 4'd9, 32'd8, 64'd1);
		send_beat(1'b1, 1'b1, 64'hFEDC_BA98_7654_3210, 4'd15, 32'd8, '1);
		// stray beat right after a finished message
		send_beat(1'b0, 1'b0, '1, 4'd8, '1, '1);
		// short counts on body words, wrong length, then a short tail
		send_beat(1'b1, 1'b0, '1, 4'd3, 32'd1000, 64'h8000_0000_0000_0001);
		send_beat(1'b0, 1'b0, 64'h8000_0000_0000_0000, 4'd0, '1, '1);
		send_beat(1'b0, 1'b1, '1, 4'd5, '1, '1);
		// restart in the middle of a message
		send_beat(1'b1, 1'b0, '1, 4'd8, 32'd24, '1);
		send_beat(1'b1, 1'b0, 64'd7, 4'd8, 32'd16, 64'd3);
		send_beat(1'b0, 1'b1, 64'hDEAD_BEEF_CAFE_F00D, 4'd8, 32'd0, 64'd0);
		wait_for_hashes();
	endtask

	// One message: mostly well formed, some stray or abandoned beats
	task automatic send_random_message();
		int          pick;
		int          words;
		int          i;
		logic [3:0]  tail;
		logic [31:0] len;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send_beat(1'b0, 1'($urandom_range(1)), rand64(), 4'($urandom_range(15)),
				$urandom, rand64());
			return;
		end
		// abandon a message part way; the next one restarts the hash
		if (pick < 16) begin
			send_beat(1'b1, 1'b0, rand64(), body_count(), $urandom, rand64());
			repeat ($urandom_range(2))
				send_beat(1'b0, 1'b0, rand64(), body_count(), $urandom, rand64());
		end
		words = ($urandom_range(9) == 0) ? $urandom_range(4, 16) : $urandom_range(3);
		tail = ($urandom_range(99) < 15) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(WORD_BYTES));
		len = ($urandom_range(99) < 85)
			? 32'(words * WORD_BYTES + ((tail > WORD_BYTES) ? WORD_BYTES : tail))
			: $urandom;
		if (words == 0) begin
			send_beat(1'b1, 1'b1, rand64(), tail, len, rand64());
		end else begin
			send_beat(1'b1, 1'b0, rand64(), body_count(), len, rand64());
			for (i = 1; i < words; i++)
				send_beat(1'b0, 1'b0, rand64(), body_count(), $urandom, rand64());
			send_beat(1'b0, 1'b1, rand64(), tail, $urandom, rand64());
		end
	endtask

	task automatic test_random_traffic(int beats, int send_pct, int recv_pct);
		int stop_at;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = beats_hashed + beats;
		while (beats_hashed < stop_at)
			send_random_message();
		wait_for_hashes();
	endtask

	// Hold the output long enough for the block to back up into its input
	task automatic test_output_holdoff();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		in_valid <= 1'b0;
		@(negedge clk);
		hold_cycles = 250;
		@(posedge clk);
		repeat (12)
			send_beat(1'b1, 1'b1, rand64(), 4'($urandom_range(WORD_BYTES)),
				$urandom, rand64());
		wait_for_hashes();
	endtask

	// Pause the sender until all hashes are out, then resume
	task automatic test_sender_pause();
		repeat (3)
			send_random_message();
		wait_for_hashes();
		repeat (3)
			send_random_message();
		wait_for_hashes();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 24;
		recv_idle_pct = 79;
		test_directed();
		test_random_traffic(260, 24, 79);
		test_random_traffic(260, 79, 24);
		test_output_holdoff();
		test_sender_pause();
		test_random_traffic(260, 0, 0);
		in_valid <= 1'b0;
		repeat (DRAIN_WAIT) @(posedge clk);
		if (owed_hashes.size() != 0)
			$display("%0d hashes never delivered", owed_hashes.size());
		if (mismatch_count == 0 && owed_hashes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Abort a hung run
	initial begin
		#(CLK_PERIOD * RUN_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
